>>> hdl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants of the escaped frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_SYNC     = 3'd1,
    ST_TARGET   = 3'd2,
    ST_COUNT    = 3'd3,
    ST_CHECKSUM = 3'd4
  } efr_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS    = 2'd0,
    REG_SYNC_VALUE        = 2'd1,
    REG_ESCAPE_VALUE      = 2'd2,
    REG_BROADCAST_ADDRESS = 2'd3
  } efr_reg_t;

  localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS    = 8'd0;
  localparam logic [BYTE_W-1:0] RST_SYNC_VALUE        = 8'd224;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE      = 8'd208;
  localparam logic [BYTE_W-1:0] RST_BROADCAST_ADDRESS = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] device_address;
    logic [BYTE_W-1:0] sync_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] broadcast_address;
  } efr_cfg_t;

endpackage

`default_nettype wire

>>> hdl/efr_in_if.sv
// ----------------------------------------------------------------------------
// efr_in_if
// Raw byte channel: one line byte per transfer plus end-of-burst flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_in_if;
  logic                       valid;
  logic                       ready;
  logic [efr_pkg::BYTE_W-1:0] raw_byte;
  logic                       buffer_end;

  modport source (output valid, output raw_byte, output buffer_end, input ready);
  modport sink   (input valid, input raw_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

>>> hdl/efr_out_if.sv
// ----------------------------------------------------------------------------
// efr_out_if
// Result channel: decoded payload byte or frame status per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [efr_pkg::BYTE_W-1:0]   payload;
  logic [efr_pkg::STATUS_W-1:0] status;

  modport source (output valid, output kind, output payload, output status, input ready);
  modport sink   (input valid, input kind, input payload, input status, output ready);
endinterface

`default_nettype wire

>>> hdl/efr_cfg_if.sv
// ----------------------------------------------------------------------------
// efr_cfg_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface efr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efr_pkg::CFG_IDX_W-1:0] index;
  logic [efr_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/efr_regs.sv
// ----------------------------------------------------------------------------
// efr_regs
// Configuration register bank, written one register per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efr_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  efr_cfg_if.sink        cfg_if,
  output efr_pkg::efr_cfg_t cfg
);

  efr_pkg::efr_cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= efr_pkg::RST_DEVICE_ADDRESS;
      cfg_r.sync_value        <= efr_pkg::RST_SYNC_VALUE;
      cfg_r.escape_value      <= efr_pkg::RST_ESCAPE_VALUE;
      cfg_r.broadcast_address <= efr_pkg::RST_BROADCAST_ADDRESS;
    end else if (cfg_if.valid) begin
      case (efr_pkg::efr_reg_t'(cfg_if.index))
        efr_pkg::REG_DEVICE_ADDRESS:    cfg_r.device_address    <= cfg_if.data;
        efr_pkg::REG_SYNC_VALUE:        cfg_r.sync_value        <= cfg_if.data;
        efr_pkg::REG_ESCAPE_VALUE:      cfg_r.escape_value      <= cfg_if.data;
        efr_pkg::REG_BROADCAST_ADDRESS: cfg_r.broadcast_address <= cfg_if.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Sync hunt, unescape, target/count check, payload pass-through and checksum.
// ----------------------------------------------------------------------------
//  channel | direction | payload                      | handshake
//  in_if   | in        | raw_byte, buffer_end         | valid/ready
//  out_if  | out       | kind, payload, status        | valid/ready
//  cfg_if  | in        | index, data                  | valid/ready (always ready)
//
//  one raw byte per cycle while the byte stage is not stalled; each input
//  passes the input register, then the byte rule into the result register.
//  synchronous active-low reset returns to sync hunt and reloads registers.
//  a pending result stalls the byte stage only if that byte also yields one;
//  otherwise the input register keeps taking bytes while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver (
  input  wire logic clk,
  input  wire logic rst_n,
  efr_in_if.sink    in_if,
  efr_out_if.source out_if,
  efr_cfg_if.sink   cfg_if
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TARGET  = 3'd1,
    PH_COUNT   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  efr_pkg::efr_cfg_t cfg;

  efr_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // input register
  logic                       s1_valid_r;
  logic [efr_pkg::BYTE_W-1:0] s1_byte_r;
  logic                       s1_end_r;

  // frame state
  phase_t                     phase_r,   phase_nxt;
  logic                       esc_r,     esc_nxt;
  logic [efr_pkg::BYTE_W-1:0] sum_r,     sum_nxt;
  logic [efr_pkg::BYTE_W-1:0] left_r,    left_nxt;
  logic                       rep_r,     rep_nxt;

  // result register
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [efr_pkg::BYTE_W-1:0]  out_payload_r;
  efr_pkg::efr_status_t        out_status_r;

  logic                        res_valid;
  logic                        res_kind;
  logic [efr_pkg::BYTE_W-1:0]  res_payload;
  efr_pkg::efr_status_t        res_status;

  logic                        in_frame;
  logic [efr_pkg::BYTE_W-1:0]  dec;
  logic [efr_pkg::BYTE_W-1:0]  left_dec;
  logic                        s1_advance;
  logic                        in_ready;

  assign in_frame = (phase_r == PH_TARGET) || (phase_r == PH_COUNT) ||
                    (phase_r == PH_PAYLOAD) || (phase_r == PH_CHECK);

  always_comb begin
    phase_nxt   = phase_r;
    esc_nxt     = esc_r;
    sum_nxt     = sum_r;
    left_nxt    = left_r;
    rep_nxt     = rep_r;
    res_valid   = 1'b0;
    res_kind    = efr_pkg::KIND_STATUS;
    res_payload = '0;
    res_status  = efr_pkg::ST_OK;
    dec         = esc_r ? s1_byte_r + 8'd1 : s1_byte_r;
    left_dec    = left_r - 8'd1;

    if (s1_byte_r == cfg.sync_value) begin
      // raw sync restarts unless the byte also ends the burst, cutting off any frame in progress
      phase_nxt = PH_TARGET;
      esc_nxt   = 1'b0;
      sum_nxt   = '0;
      left_nxt  = '0;
      rep_nxt   = 1'b0;
      if (in_frame) begin
        res_valid  = 1'b1;
        res_status = efr_pkg::ST_COUNT;
      end
    end else if (!in_frame) begin
      phase_nxt = PH_HUNT;
      if (!rep_r) begin
        res_valid  = 1'b1;
        res_status = efr_pkg::ST_SYNC;
        rep_nxt    = 1'b1;
      end
    end else if (!esc_r && s1_byte_r == cfg.escape_value) begin
      esc_nxt = 1'b1;
    end else begin
      esc_nxt = 1'b0;
      case (phase_r)
        PH_TARGET: begin
          if (dec != cfg.device_address && dec != cfg.broadcast_address) begin
            res_valid  = 1'b1;
            res_status = efr_pkg::ST_TARGET;
            phase_nxt  = PH_HUNT;
            left_nxt   = '0;
            rep_nxt    = 1'b1;
          end else begin
            sum_nxt   = dec;
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (dec == '0) begin
            res_valid  = 1'b1;
            res_status = efr_pkg::ST_COUNT;
            phase_nxt  = PH_HUNT;
            left_nxt   = '0;
            rep_nxt    = 1'b1;
          end else begin
            sum_nxt   = sum_r + dec;
            left_nxt  = dec - 8'd1;
            phase_nxt = (dec != 8'd1) ? PH_PAYLOAD : PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          res_valid   = 1'b1;
          res_kind    = efr_pkg::KIND_DATA;
          res_payload = dec;
          sum_nxt     = sum_r + dec;
          left_nxt    = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_CHECK;
          end
        end
        default: begin
          res_valid  = 1'b1;
          res_status = (dec == sum_r) ? efr_pkg::ST_OK : efr_pkg::ST_CHECKSUM;
          phase_nxt  = PH_HUNT;
          left_nxt   = '0;
          rep_nxt    = 1'b1;
        end
      endcase
    end

    if (s1_end_r) begin
      // end of burst before the checksum reports a count status in place of any payload result
      if (phase_nxt != PH_HUNT) begin
        res_valid   = 1'b1;
        res_kind    = efr_pkg::KIND_STATUS;
        res_payload = '0;
        res_status  = efr_pkg::ST_COUNT;
      end
      phase_nxt = PH_HUNT;
      esc_nxt   = 1'b0;
      left_nxt  = '0;
      rep_nxt   = 1'b0;
    end
  end

  assign s1_advance   = s1_valid_r && (!res_valid || !out_valid_r || out_if.ready);
  assign in_ready     = !s1_valid_r || s1_advance;
  assign in_if.ready  = in_ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.kind    = out_kind_r;
  assign out_if.payload = out_payload_r;
  assign out_if.status  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s1_byte_r     <= '0;
      s1_end_r      <= 1'b0;
      phase_r       <= PH_HUNT;
      esc_r         <= 1'b0;
      sum_r         <= '0;
      left_r        <= '0;
      rep_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_kind_r    <= efr_pkg::KIND_DATA;
      out_payload_r <= '0;
      out_status_r  <= efr_pkg::ST_OK;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_if.valid;
        s1_byte_r  <= in_if.raw_byte;
        s1_end_r   <= in_if.buffer_end;
      end
      if (s1_advance) begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
        sum_r   <= sum_nxt;
        left_r  <= left_nxt;
        rep_r   <= rep_nxt;
      end
      if (s1_advance && res_valid) begin
        out_valid_r   <= 1'b1;
        out_kind_r    <= res_kind;
        out_payload_r <= res_payload;
        out_status_r  <= res_status;
      end else if (out_if.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_status_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == efr_pkg::KIND_STATUS |-> out_payload_r == '0)
    else $error("status result carries a payload byte");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == efr_pkg::KIND_DATA |-> out_status_r == efr_pkg::ST_OK)
    else $error("payload result carries a status code");

  a_escape_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r == PH_TARGET || phase_r == PH_COUNT ||
               phase_r == PH_PAYLOAD || phase_r == PH_CHECK))
    else $error("escape pending outside a frame");

  a_left_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != '0 |-> phase_r == PH_PAYLOAD)
    else $error("byte count left outside payload phase");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready && s1_valid_r && res_valid |=> $stable(phase_r))
    else $error("frame state moved while its result was blocked");
`endif

endmodule

`default_nettype wire
